/* design/lsft_pkg.sv */
`timescale 1ns / 1ps

package lsft_pkg;

    localparam logic [1:0] OP_COMMAND  = 2'd0;
    localparam logic [1:0] OP_DATA     = 2'd1;
    localparam logic [1:0] OP_POSITION = 2'd2;

    localparam logic [7:0] SYNC_COMMAND = 8'hF8;
    localparam logic [7:0] SYNC_DATA    = 8'hFA;
    localparam logic [7:0] ADDR_COMMAND = 8'h80;
    localparam logic [3:0] FOLD_COL     = 4'd8;

    localparam int FRAME_BITS = 24;
    localparam int CNT_W      = $clog2(FRAME_BITS);
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] value;
        logic [3:0] column_word;
        logic [5:0] row;
    } req_t;

    typedef struct packed {
        logic serial_bit;
        logic frame_start;
        logic last_bit;
    } tx_t;

    // One queued job: one or two frames; the second frame is always a command
    typedef struct packed {
        logic       two_frames;
        logic       is_data;
        logic [7:0] byte0;
        logic [7:0] byte1;
    } job_t;

    function automatic logic [FRAME_BITS-1:0] build_frame(input logic [7:0] sync,
                                                          input logic [7:0] data);
        build_frame = {sync, data[7:4], 4'h0, data[3:0], 4'h0};
    endfunction

endpackage

/* design/lcd_serial_frame_transmitter.sv */
`timescale 1ns / 1ps

// Serial write-frame transmitter: each request word becomes 24 wire bits (command or
// data byte) or 48 (cursor position: Y then X address command), one bit per result
// word, MSB first. The back end sends one bit per cycle, unless the output is stalled,
// from a frame shift register; before each request it passes through its idle state,
// where it loads the frame from the two-entry job queue. Opcode 3 is taken and
// produces nothing.
module lcd_serial_frame_transmitter
    import lsft_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req_data,
    output logic tx_valid,
    input  logic tx_stall,
    output tx_t  tx_data
);

    job_t job_in;
    job_t job_out;
    logic keep;
    logic full;
    logic job_valid;
    logic job_pop;

    assign req_stall = full;

    lsft_front u_front (
        .req_data (req_data),
        .job      (job_in),
        .keep     (keep)
    );

    lsft_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (req_valid && keep),
        .push_job  (job_in),
        .full      (full),
        .pop_valid (job_valid),
        .pop       (job_pop),
        .pop_job   (job_out)
    );

    lsft_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job_out),
        .job_pop   (job_pop),
        .tx_valid  (tx_valid),
        .tx_stall  (tx_stall),
        .tx_data   (tx_data)
    );

endmodule

/* design/lsft_front.sv */
`timescale 1ns / 1ps

module lsft_front
    import lsft_pkg::*;
(
    input  req_t req_data,
    output job_t job,
    output logic keep
);

    logic       fold;
    logic [5:0] row_f;
    logic [3:0] col_f;

    // Fold the lower half of the panel onto the upper rows
    assign fold  = req_data.row[5];
    assign row_f = {1'b0, req_data.row[4:0]};
    assign col_f = req_data.column_word + (fold ? FOLD_COL : 4'd0);

    always_comb
    begin
        job        = '0;
        keep       = 1'b0;
        case (req_data.opcode)
            OP_COMMAND:
            begin
                keep      = 1'b1;
                job.byte0 = req_data.value;
            end
            OP_DATA:
            begin
                keep        = 1'b1;
                job.is_data = 1'b1;
                job.byte0   = req_data.value;
            end
            OP_POSITION:
            begin
                keep           = 1'b1;
                job.two_frames = 1'b1;
                job.byte0      = ADDR_COMMAND | {2'b00, row_f};
                job.byte1      = ADDR_COMMAND | {4'h0, col_f};
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

endmodule

/* design/lsft_fifo.sv */
`timescale 1ns / 1ps

module lsft_fifo
    import lsft_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    output logic pop_valid,
    input  logic pop,
    output job_t pop_job
);

    job_t                 mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wptr_reg, wptr_next;
    logic [FIFO_AW-1:0]   rptr_reg, rptr_next;
    logic [FIFO_AW:0]     count_reg, count_next;
    logic                 do_push, do_pop;

    assign full      = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;
    assign pop_job   = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = do_push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = do_pop ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= push_job;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("queue count beyond depth");

endmodule

/* design/lsft_back.sv */
`timescale 1ns / 1ps

module lsft_back
    import lsft_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic job_valid,
    input  job_t job,
    output logic job_pop,
    output logic tx_valid,
    input  logic tx_stall,
    output tx_t  tx_data
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SEND = 2'b10
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [FRAME_BITS-1:0]  frame_reg, frame_next;
    logic                   pending_reg, pending_next;
    logic [7:0]             second_reg, second_next;
    logic                   valid_reg, valid_next;
    tx_t                    word_reg, word_next;
    logic                   advance;
    logic                   frame_end;

    assign advance   = !valid_reg || !tx_stall;
    assign frame_end = (cnt_reg == CNT_W'(FRAME_BITS - 1));
    assign job_pop   = (state_reg == ST_IDLE);
    assign tx_valid  = valid_reg;
    assign tx_data   = word_reg;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        frame_next   = frame_reg;
        pending_next = pending_reg;
        second_next  = second_reg;
        valid_next   = valid_reg;
        word_next    = word_reg;
        if (advance)
        begin
            valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    frame_next   = build_frame(job.is_data ? SYNC_DATA : SYNC_COMMAND,
                                               job.byte0);
                    pending_next = job.two_frames;
                    second_next  = job.byte1;
                    cnt_next     = '0;
                    state_next   = ST_SEND;
                end
            end
            ST_SEND:
            begin
                if (advance)
                begin
                    valid_next            = 1'b1;
                    word_next.serial_bit  = frame_reg[FRAME_BITS-1];
                    word_next.frame_start = (cnt_reg == '0);
                    word_next.last_bit    = frame_end && !pending_reg;
                    frame_next            = {frame_reg[FRAME_BITS-2:0], 1'b0};
                    cnt_next              = cnt_reg + 1'b1;
                    if (frame_end)
                    begin
                        cnt_next = '0;
                        if (pending_reg)
                        begin
                            // Chain the X address frame straight on
                            frame_next   = build_frame(SYNC_COMMAND, second_reg);
                            pending_next = 1'b0;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            pending_reg <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            pending_reg <= pending_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg  <= frame_next;
        second_reg <= second_next;
        word_reg   <= word_next;
    end

    a_start_is_one: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && word_reg.frame_start |-> word_reg.serial_bit)
        else $error("frame does not open with a sync one");

    a_start_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> !(word_reg.frame_start && word_reg.last_bit))
        else $error("first and last bit of a frame coincide");

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !pending_reg)
        else $error("second frame left pending while idle");

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import lsft_pkg::*;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam logic [5:0] ROW_FOLD   = 6'd32;
    localparam int         QUIET_MAX  = 2000;
    localparam int         DRAIN_WAIT = 60;
    localparam int         PRINT_MAX  = 40;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req_data;
    logic tx_valid;
    logic tx_stall;
    tx_t  tx_data;

    tx_t  expected_bits[$];
    tx_t  bit_due;
    int   errors;
    int   quiet_cycles;
    int   gap_pct;
    bit   no_idle;

    lcd_serial_frame_transmitter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .tx_valid  (tx_valid),
        .tx_stall  (tx_stall),
        .tx_data   (tx_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= PRINT_MAX)
            $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
    endtask

    // One 24-bit frame: sync byte, then each nibble of the payload in the top four bits
    function automatic void queue_frame(input logic [7:0] sync, input logic [7:0] payload,
                                        input logic ends_request);
        logic [7:0] frame_bytes [3];
        tx_t        b;
        frame_bytes[0] = sync;
        frame_bytes[1] = {payload[7:4], 4'h0};
        frame_bytes[2] = {payload[3:0], 4'h0};
        for (int k = 0; k < 3; k++)
        begin
            for (int i = 7; i >= 0; i--)
            begin
                b.serial_bit  = frame_bytes[k][i];
                b.frame_start = (k == 0) && (i == 7);
                b.last_bit    = ends_request && (k == 2) && (i == 0);
                expected_bits.push_back(b);
            end
        end
    endfunction

    function automatic void predict_wire_bits(input req_t r);
        logic [5:0] y;
        logic [3:0] x;
        y = r.row;
        x = r.column_word;
        case (r.opcode)
            OP_COMMAND:  queue_frame(SYNC_COMMAND, r.value, 1'b1);
            OP_DATA:     queue_frame(SYNC_DATA, r.value, 1'b1);
            OP_POSITION:
            begin
                // fold the lower half of the panel onto the upper rows, columns moved up by eight
                if (y >= ROW_FOLD)
                begin
                    y = y - ROW_FOLD;
                    x = x + FOLD_COL;
                end
                queue_frame(SYNC_COMMAND, ADDR_COMMAND | {2'b00, y}, 1'b0);
                queue_frame(SYNC_COMMAND, ADDR_COMMAND | {4'b0000, x}, 1'b1);
            end
            default: ; // unused opcode: taken, nothing on the wire
        endcase
    endfunction

    task automatic send_request(input req_t r);
        @(negedge clk);
        if (!no_idle && ($urandom_range(0, 99) < gap_pct))
        begin
            req_valid = 1'b0;
            req_data  = req_t'($urandom);
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        req_valid = 1'b1;
        req_data  = r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predict_wire_bits(r);
    endtask

    function automatic req_t make_request(input logic [1:0] op, input logic [7:0] v,
                                          input logic [3:0] col, input logic [5:0] y);
        req_t r;
        r.opcode      = op;
        r.value       = v;
        r.column_word = col;
        r.row         = y;
        return r;
    endfunction

    function automatic req_t random_request();
        req_t r;
        int   roll;
        r    = req_t'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 30)
            r.opcode = OP_COMMAND;
        else if (roll < 60)
            r.opcode = OP_DATA;
        else if (roll < 95)
            r.opcode = OP_POSITION;
        else
            r.opcode = OP_UNUSED;
        // lean on the fold boundary
        case ($urandom_range(0, 7))
            0: r.row = 6'd31;
            1: r.row = 6'd32;
            2: r.row = 6'd63;
            default: ;
        endcase
        return r;
    endfunction

    task automatic test_byte_writes();
        send_request(make_request(OP_COMMAND, 8'h00, 4'h0, 6'd0));
        send_request(make_request(OP_COMMAND, 8'hFF, 4'hF, 6'd63));
        send_request(make_request(OP_COMMAND, 8'hA5, 4'h5, 6'd21));
        send_request(make_request(OP_DATA, 8'h00, 4'hF, 6'd63));
        send_request(make_request(OP_DATA, 8'hFF, 4'h0, 6'd0));
        send_request(make_request(OP_DATA, 8'h5A, 4'hA, 6'd42));
        send_request(make_request(OP_DATA, 8'h81, 4'h3, 6'd7));
    endtask

    task automatic test_cursor_positions();
        send_request(make_request(OP_POSITION, 8'h00, 4'h0, 6'd0));
        send_request(make_request(OP_POSITION, 8'hFF, 4'hF, 6'd31));
        send_request(make_request(OP_POSITION, 8'h00, 4'h0, 6'd32));
        send_request(make_request(OP_POSITION, 8'h3C, 4'h7, 6'd32));
        // folded columns 8 to 15 wrap round to 0 to 7
        send_request(make_request(OP_POSITION, 8'hFF, 4'h8, 6'd33));
        send_request(make_request(OP_POSITION, 8'h00, 4'hF, 6'd63));
        send_request(make_request(OP_POSITION, 8'hC3, 4'h3, 6'd45));
        send_request(make_request(OP_POSITION, 8'h12, 4'hA, 6'd16));
    endtask

    task automatic test_unused_opcode();
        send_request(make_request(OP_UNUSED, 8'hFF, 4'hF, 6'd63));
        send_request(make_request(OP_COMMAND, 8'h30, 4'h0, 6'd0));
        send_request(make_request(OP_UNUSED, 8'h00, 4'h0, 6'd0));
        send_request(make_request(OP_UNUSED, 8'h55, 4'h9, 6'd40));
        send_request(make_request(OP_DATA, 8'hC0, 4'h1, 6'd2));
    endtask

    task automatic test_random_traffic(input int count);
        int   sent;
        req_t r;
        sent = 0;
        while (sent < count)
        begin
            if (sent % 40 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: gap_pct = 0;
                    1: gap_pct = 15;
                    default: gap_pct = 40;
                endcase
            end
            r = random_request();
            send_request(r);
            if (r.opcode != OP_UNUSED)
                sent++;
        end
    endtask

    task automatic test_steady_stream(input int count);
        no_idle = 1'b1;
        test_random_traffic(count);
    endtask

    // Output stall: random bursts, with calm stretches in between
    initial
    begin
        tx_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!no_idle)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    repeat ($urandom_range(20, 60)) @(negedge clk);
                end
                else if ($urandom_range(0, 3) == 0)
                begin
                    tx_stall = 1'b1;
                    repeat ($urandom_range(1, 5) - 1) @(negedge clk);
                    @(negedge clk);
                    tx_stall = 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && tx_valid && !tx_stall)
        begin
            if (expected_bits.size() == 0)
                report_mismatch("unexpected wire bit", tx_data.serial_bit, 0);
            else
            begin
                bit_due = expected_bits.pop_front();
                if (tx_data.serial_bit !== bit_due.serial_bit)
                    report_mismatch("serial_bit", tx_data.serial_bit, bit_due.serial_bit);
                if (tx_data.frame_start !== bit_due.frame_start)
                    report_mismatch("frame_start", tx_data.frame_start, bit_due.frame_start);
                if (tx_data.last_bit !== bit_due.last_bit)
                    report_mismatch("last_bit", tx_data.last_bit, bit_due.last_bit);
            end
        end
    end

    // Watchdog: count cycles in which neither side moves a word
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (tx_valid && !tx_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_MAX)
        begin
            $display("timeout: no word moved for %0d cycles", QUIET_MAX);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req_data     = '0;
        errors       = 0;
        quiet_cycles = 0;
        gap_pct      = 20;
        no_idle      = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        test_byte_writes();
        test_cursor_positions();
        test_unused_opcode();
        test_random_traffic(360);
        test_steady_stream(60);

        @(negedge clk);
        req_valid = 1'b0;
        wait (expected_bits.size() == 0);
        // hold a while longer to catch stray bits
        repeat (DRAIN_WAIT) @(posedge clk);

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
